// ===== rtl/core/eui_address_discovery_engine_macros.svh =====
// Assertion macros used by the port-level checker file of the discovery engine.
// Include by bare file name; every macro names its own label.
`ifndef EUI_ADDRESS_DISCOVERY_ENGINE_MACROS_SVH
`define EUI_ADDRESS_DISCOVERY_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EADE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eade check failed");

// Next-cycle implication, disabled during reset.
`define EADE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eade check failed");

`endif

// ===== rtl/core/eade_pkg.sv =====
// Types and codes of the EUI address discovery engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package eade_pkg;

    // Input action codes
    localparam logic [2:0] ACT_RX_REQ    = 3'd0;
    localparam logic [2:0] ACT_RX_RSP    = 3'd1;
    localparam logic [2:0] ACT_QRY_ADDR  = 3'd2;
    localparam logic [2:0] ACT_QRY_EUI   = 3'd3;
    localparam logic [2:0] ACT_SEND      = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_CACHE    = 2'd1;
    localparam logic [1:0] KIND_SEND_RSP = 2'd2;
    localparam logic [1:0] KIND_SEND_REQ = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_MY_SHORT  = 2'd0;
    localparam logic [1:0] REG_MY_EUI    = 2'd1;

    localparam logic [63:0] ALL_ONES_GUID = {64{1'b1}};

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RX_REQ,
        OP_RX_RSP,
        OP_QRY_ADDR,
        OP_QRY_EUI,
        OP_SEND
    } op_t;

    // Classified request as it travels through the queue
    typedef struct packed {
        op_t         op;
        logic        answer;
        logic [15:0] addr;
        logic [63:0] eui;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== rtl/core/eade_front.sv =====
// Front end: accepts input requests and classifies them into queue entries.
// Depends on eade_pkg.
`timescale 1ns / 1ps

module eade_front #(
    parameter int unsigned BROADCAST_ADDR = 65535
) (
    input  logic            in_valid,
    input  logic [2:0]      action,
    input  logic [15:0]     dest_addr,
    input  logic [15:0]     src_addr,
    input  logic [63:0]     eui_value,
    input  logic [15:0]     my_short,
    input  logic [63:0]     my_eui,
    input  eade_pkg::q_stat_t q_stat,
    output logic            in_stall,
    output logic            push,
    output eade_pkg::entry_t entry
);
    import eade_pkg::*;

    logic to_bcast;
    logic to_me;
    logic mine;
    logic ones;

    assign to_bcast = (dest_addr == 16'(BROADCAST_ADDR));
    assign to_me    = (dest_addr == my_short);
    assign mine     = (eui_value == my_eui);
    assign ones     = (eui_value == ALL_ONES_GUID);

    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    always_comb
    begin
        entry.answer = (to_bcast && mine) || (to_me && (ones || mine));
        entry.addr   = src_addr;
        entry.eui    = eui_value;
        unique case (action)
            ACT_RX_REQ:   entry.op = OP_RX_REQ;
            ACT_RX_RSP:   entry.op = OP_RX_RSP;
            ACT_QRY_ADDR: entry.op = OP_QRY_ADDR;
            ACT_QRY_EUI:  entry.op = OP_QRY_EUI;
            ACT_SEND:     entry.op = OP_SEND;
            default:      entry.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/core/eade_queue.sv =====
// Short queue between front end and back end.
// Depends on eade_pkg for the entry and status types.
`timescale 1ns / 1ps

module eade_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  eade_pkg::entry_t wdata,
    input  logic             pop,
    output eade_pkg::entry_t rdata,
    output eade_pkg::q_stat_t q_stat
);
    import eade_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign rdata        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/core/eade_back.sv =====
// Back end: executes queued entries against the pending slots and
// drives the result register. Depends on eade_pkg.
`timescale 1ns / 1ps

module eade_back #(
    parameter int unsigned BROADCAST_ADDR = 65535
) (
    input  logic              clk,
    input  logic              rst_n,
    input  eade_pkg::entry_t  entry,
    input  eade_pkg::q_stat_t q_stat,
    input  logic [63:0]       my_eui,
    input  logic              out_stall,
    output logic              pop,
    output logic              out_valid,
    output logic [1:0]        out_kind,
    output logic [15:0]       out_addr,
    output logic [63:0]       out_eui
);
    import eade_pkg::*;

    logic [15:0] reply_reg;
    logic [15:0] reply_next;
    logic [15:0] qaddr_reg;
    logic [15:0] qaddr_next;
    logic [63:0] qeui_reg;
    logic [63:0] qeui_next;
    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [1:0]  kind_next;
    logic [15:0] addr_reg;
    logic [15:0] addr_next;
    logic [63:0] eui_reg;
    logic [63:0] eui_next;

    // Take the next entry when the result register is free or being drained
    assign pop = !q_stat.empty && (!valid_reg || !out_stall);

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_addr  = addr_reg;
    assign out_eui   = eui_reg;

    always_comb
    begin
        reply_next = reply_reg;
        qaddr_next = qaddr_reg;
        qeui_next  = qeui_reg;
        kind_next  = KIND_NONE;
        addr_next  = '0;
        eui_next   = '0;
        unique case (entry.op)
            OP_RX_REQ:
            begin
                if (entry.answer)
                begin
                    // collapse to broadcast when a different source is pending
                    if (reply_reg != '0 && reply_reg != entry.addr)
                    begin
                        reply_next = 16'(BROADCAST_ADDR);
                    end
                    else
                    begin
                        reply_next = entry.addr;
                    end
                end
            end
            OP_RX_RSP:
            begin
                kind_next = KIND_CACHE;
                addr_next = entry.addr;
                eui_next  = entry.eui;
            end
            OP_QRY_ADDR:
            begin
                if (qaddr_reg == '0)
                begin
                    qaddr_next = entry.addr;
                end
            end
            OP_QRY_EUI:
            begin
                if (qeui_reg == '0)
                begin
                    qeui_next = entry.eui;
                end
            end
            OP_SEND:
            begin
                priority if (reply_reg != '0)
                begin
                    kind_next  = KIND_SEND_RSP;
                    addr_next  = reply_reg;
                    eui_next   = my_eui;
                    reply_next = '0;
                end
                else if (qaddr_reg != '0)
                begin
                    kind_next  = KIND_SEND_REQ;
                    addr_next  = qaddr_reg;
                    eui_next   = ALL_ONES_GUID;
                    qaddr_next = '0;
                end
                else if (qeui_reg != '0)
                begin
                    kind_next = KIND_SEND_REQ;
                    addr_next = 16'(BROADCAST_ADDR);
                    eui_next  = qeui_reg;
                    qeui_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_reg <= '0;
            qaddr_reg <= '0;
            qeui_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                reply_reg <= reply_next;
                qaddr_reg <= qaddr_next;
                qeui_reg  <= qeui_next;
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; hold while stalled
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= kind_next;
            addr_reg <= addr_next;
            eui_reg  <= eui_next;
        end
    end

endmodule

// ===== rtl/core/eui_address_discovery_engine.sv =====
// Top level of the EUI address discovery engine: configuration registers,
// front end, queue and back end. Depends on eade_pkg and the eade_* modules.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  input    | in_valid / in_stall | action, dest_addr, src_addr, eui_value
//  result   | out_valid/out_stall | out_kind, out_addr, out_eui
//  config   | cfg_we              | cfg_index, cfg_data
//
// One request per cycle sustained while in_stall is low; every request gives exactly one result.
// With an empty queue, the accepting edge writes the queue; once the result register is free or
// being drained, the entry goes through the slot update into the result register and out_valid rises.
// A stalled result holds; the queue (DEPTH entries) keeps accepting until full.
// Reset clears the pending slots, the queue and both configuration registers.
`timescale 1ns / 1ps

module eui_address_discovery_engine #(
    parameter int unsigned BROADCAST_ADDR = 65535,
    parameter int unsigned DEPTH          = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [15:0] dest_addr,
    input  logic [15:0] src_addr,
    input  logic [63:0] eui_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  out_kind,
    output logic [15:0] out_addr,
    output logic [63:0] out_eui
);
    import eade_pkg::*;

    logic [15:0] my_short_reg;
    logic [63:0] my_eui_reg;
    logic        push;
    logic        pop;
    entry_t      wr_entry;
    entry_t      rd_entry;
    q_stat_t     q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_short_reg <= '0;
            my_eui_reg   <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MY_SHORT)
            begin
                my_short_reg <= cfg_data[15:0];
            end
            else if (cfg_index == REG_MY_EUI)
            begin
                my_eui_reg <= cfg_data;
            end
        end
    end

    eade_front #(
        .BROADCAST_ADDR(BROADCAST_ADDR)
    ) u_front (
        .in_valid (in_valid),
        .action   (action),
        .dest_addr(dest_addr),
        .src_addr (src_addr),
        .eui_value(eui_value),
        .my_short (my_short_reg),
        .my_eui   (my_eui_reg),
        .q_stat   (q_stat),
        .in_stall (in_stall),
        .push     (push),
        .entry    (wr_entry)
    );

    eade_queue #(
        .DEPTH(DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wr_entry),
        .pop   (pop),
        .rdata (rd_entry),
        .q_stat(q_stat)
    );

    eade_back #(
        .BROADCAST_ADDR(BROADCAST_ADDR)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .entry    (rd_entry),
        .q_stat   (q_stat),
        .my_eui   (my_eui_reg),
        .out_stall(out_stall),
        .pop      (pop),
        .out_valid(out_valid),
        .out_kind (out_kind),
        .out_addr (out_addr),
        .out_eui  (out_eui)
    );

endmodule

// ===== rtl/core/eade_checker.sv =====
// Port-level checker for the discovery engine, bound to the top level.
// Depends on eade_pkg and eui_address_discovery_engine_macros.svh.
`timescale 1ns / 1ps
`include "eui_address_discovery_engine_macros.svh"

module eade_checker #(
    parameter int unsigned BROADCAST_ADDR = 65535
) (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic [1:0]  cfg_index,
    input logic [63:0] cfg_data,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  out_kind,
    input logic [15:0] out_addr,
    input logic [63:0] out_eui
);
    import eade_pkg::*;

    logic [63:0] shadow_eui_reg;

    // Track the configured EUI from the write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_eui_reg <= '0;
        end
        else if (cfg_we && cfg_index == REG_MY_EUI)
        begin
            shadow_eui_reg <= cfg_data;
        end
    end

    `EADE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_addr) && $stable(out_eui))
    `EADE_ASSERT_IMPL(a_none_zero, clk, rst_n, out_valid && out_kind == KIND_NONE, out_addr == '0 && out_eui == '0)
    `EADE_ASSERT_IMPL(a_rsp_eui, clk, rst_n, out_valid && out_kind == KIND_SEND_RSP, out_eui == shadow_eui_reg && out_addr != '0)
    `EADE_ASSERT_IMPL(a_req_form, clk, rst_n, out_valid && out_kind == KIND_SEND_REQ, (out_eui == ALL_ONES_GUID && out_addr != '0) || (out_addr == 16'(BROADCAST_ADDR) && out_eui != '0))

endmodule

bind eui_address_discovery_engine eade_checker #(
    .BROADCAST_ADDR(BROADCAST_ADDR)
) u_eade_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind (out_kind),
    .out_addr (out_addr),
    .out_eui  (out_eui)
);

// ===== tb/sv/eade_checker.sv =====
// Result checker for the EUI address discovery engine: watches the config port and both
// channels, predicts each result and compares it. Depends on eade_pkg.
`timescale 1ns / 1ps

module eade_tb_checker #(
    parameter int unsigned BROADCAST_ADDR = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  action,
    input  logic [15:0] dest_addr,
    input  logic [15:0] src_addr,
    input  logic [63:0] eui_value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  out_kind,
    input  logic [15:0] out_addr,
    input  logic [63:0] out_eui,
    output int          fail_count,
    output int          open_results
);

    import eade_pkg::*;

    localparam logic [15:0] BCAST = BROADCAST_ADDR[15:0];

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [63:0] eui;
    } discovery_result_t;

    discovery_result_t expected_results[$];

    logic [15:0] my_short;
    logic [63:0] my_eui;
    logic [15:0] reply_dest;
    logic [15:0] addr_query;
    logic [63:0] eui_query;
    int          mismatches = 0;

    always @(posedge clk or negedge rst_n)
    begin : track
        discovery_result_t want;
        logic              answer;
        if (!rst_n)
        begin
            my_short   = '0;
            my_eui     = '0;
            reply_dest = '0;
            addr_query = '0;
            eui_query  = '0;
            expected_results.delete();
            open_results <= 0;
            fail_count   <= mismatches;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MY_SHORT: my_short = cfg_data[15:0];
                    REG_MY_EUI:   my_eui   = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none expected: expected none, %s %0d %h %h",
                             $time, "got kind/addr/eui", out_kind, out_addr, out_eui);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_kind !== want.kind)
                    begin
                        $display("%0t: out_kind expected %0d got %0d", $time, want.kind, out_kind);
                        mismatches++;
                    end
                    if (out_addr !== want.addr)
                    begin
                        $display("%0t: out_addr expected %h got %h", $time, want.addr, out_addr);
                        mismatches++;
                    end
                    if (out_eui !== want.eui)
                    begin
                        $display("%0t: out_eui expected %h got %h", $time, want.eui, out_eui);
                        mismatches++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                want = '{kind: KIND_NONE, addr: '0, eui: '0};
                case (action)
                    ACT_RX_REQ:
                    begin
                        answer = ((dest_addr == BCAST) && (eui_value == my_eui))
                              || ((dest_addr == my_short)
                                  && ((eui_value == ALL_ONES_GUID) || (eui_value == my_eui)));
                        if (answer)
                        begin
                            // collapse to broadcast when a different source already waits
                            if ((reply_dest != '0) && (reply_dest != src_addr))
                                reply_dest = BCAST;
                            else
                                reply_dest = src_addr;
                        end
                    end
                    ACT_RX_RSP:
                        want = '{kind: KIND_CACHE, addr: src_addr, eui: eui_value};
                    ACT_QRY_ADDR:
                        if (addr_query == '0)
                            addr_query = src_addr;
                    ACT_QRY_EUI:
                        if (eui_query == '0)
                            eui_query = eui_value;
                    ACT_SEND:
                    begin
                        if (reply_dest != '0)
                        begin
                            want = '{kind: KIND_SEND_RSP, addr: reply_dest, eui: my_eui};
                            reply_dest = '0;
                        end
                        else if (addr_query != '0)
                        begin
                            want = '{kind: KIND_SEND_REQ, addr: addr_query, eui: ALL_ONES_GUID};
                            addr_query = '0;
                        end
                        else if (eui_query != '0)
                        begin
                            want = '{kind: KIND_SEND_REQ, addr: BCAST, eui: eui_query};
                            eui_query = '0;
                        end
                    end
                    default: ;
                endcase
                expected_results.push_back(want);
            end

            open_results <= expected_results.size();
            fail_count   <= mismatches;
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the discovery engine testbench: clock, reset, config writes, request stimulus
// and result stalls. Depends on eade_pkg, eade_tb_checker and the engine RTL.
`timescale 1ns / 1ps

module testbench;

    import eade_pkg::*;

    localparam int unsigned BROADCAST_ADDR = 65535;
    localparam logic [15:0] BCAST          = 16'hFFFF;
    localparam int          PHASES         = 6;
    localparam int          PHASE_ITEMS    = 305;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [15:0] dest_addr;
    logic [15:0] src_addr;
    logic [63:0] eui_value;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  out_kind;
    logic [15:0] out_addr;
    logic [63:0] out_eui;
    int          fail_count;
    int          open_results;

    logic [15:0] cur_short;
    logic [63:0] cur_eui;
    bit          no_gaps;

    eui_address_discovery_engine #(
        .BROADCAST_ADDR(BROADCAST_ADDR)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .dest_addr(dest_addr), .src_addr(src_addr), .eui_value(eui_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_kind(out_kind), .out_addr(out_addr), .out_eui(out_eui)
    );

    eade_tb_checker #(
        .BROADCAST_ADDR(BROADCAST_ADDR)
    ) u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .dest_addr(dest_addr), .src_addr(src_addr), .eui_value(eui_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_kind(out_kind), .out_addr(out_addr), .out_eui(out_eui),
        .fail_count(fail_count), .open_results(open_results)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic push_request(input logic [2:0] act, input logic [15:0] dest,
                                input logic [15:0] src, input logic [63:0] guid);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        dest_addr <= dest;
        src_addr  <= src;
        eui_value <= guid;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // drain every pending result, then write one register
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        in_valid <= 1'b0;
        @(posedge clk);
        while (open_results != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_identity(input logic [15:0] short_addr, input logic [63:0] eui);
        cur_short = short_addr;
        cur_eui   = eui;
        write_reg(REG_MY_SHORT, {16'($urandom), $urandom, short_addr});
        write_reg(REG_MY_EUI, eui);
    endtask

    // result-side stalls
    initial
    begin
        int hold;
        int run;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            hold = pick_gap();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            run = ($urandom_range(0, 99) < 5) ? $urandom_range(50, 150) : $urandom_range(1, 4);
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [2:0]  act;
        logic [15:0] dest;
        logic [15:0] src;
        logic [63:0] guid;
        int          r;
        int          counted;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_MY_SHORT;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        action    <= ACT_RX_REQ;
        dest_addr <= '0;
        src_addr  <= '0;
        eui_value <= '0;
        cur_short = '0;
        cur_eui   = '0;
        no_gaps   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity still at its reset value
        push_request(ACT_RX_RSP, 16'h0000, BCAST, ALL_ONES_GUID);
        push_request(ACT_RX_RSP, BCAST, 16'h0000, 64'h0);
        push_request(ACT_SEND, 16'h0000, 16'h0000, 64'h0);
        push_request(3'd5, BCAST, BCAST, ALL_ONES_GUID);
        push_request(3'd6, 16'h1234, 16'h0042, 64'h1);
        push_request(3'd7, 16'h0000, 16'h0001, 64'h0);
        push_request(ACT_QRY_ADDR, 16'h0000, 16'h0000, ALL_ONES_GUID);
        push_request(ACT_QRY_EUI, 16'h0000, BCAST, 64'h0);
        push_request(ACT_SEND, BCAST, BCAST, ALL_ONES_GUID);

        set_identity(16'h1234, 64'hA5A5_0F0F_C3C3_9696);
        push_request(ACT_RX_REQ, BCAST, 16'h0042, cur_eui);
        // a different source while an answer waits: collapse to broadcast
        push_request(ACT_RX_REQ, cur_short, 16'h0077, ALL_ONES_GUID);
        push_request(ACT_SEND, 16'h0000, 16'h0000, 64'h0);
        // answer from address zero leaves nothing pending
        push_request(ACT_RX_REQ, cur_short, 16'h0000, cur_eui);
        push_request(ACT_SEND, 16'h0000, 16'h0000, 64'h0);
        push_request(ACT_RX_REQ, cur_short, 16'h0005, 64'h0123_4567_89AB_CDEF);
        push_request(ACT_QRY_ADDR, 16'h0000, BCAST, 64'h0);
        push_request(ACT_QRY_ADDR, 16'h0000, 16'h5555, 64'h0);
        push_request(ACT_QRY_EUI, 16'h0000, 16'h0000, ALL_ONES_GUID);
        push_request(ACT_QRY_EUI, 16'h0000, 16'h0000, 64'h1);
        push_request(ACT_RX_REQ, BCAST, 16'h0010, cur_eui);
        push_request(ACT_RX_REQ, BCAST, 16'h0010, cur_eui);
        repeat (4) push_request(ACT_SEND, 16'h0000, 16'h0000, 64'h0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: set_identity(BCAST, ALL_ONES_GUID);
                1: set_identity(16'h0000, 64'h0);
                default: set_identity(16'($urandom_range(0, 65535)), rand64());
            endcase
            no_gaps = (phase == 2);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                dest = 16'($urandom_range(0, 65535));
                src  = 16'($urandom_range(0, 65535));
                guid = rand64();
                r    = $urandom_range(0, 99);
                if (r < 35)
                begin
                    act = ACT_RX_REQ;
                    r = $urandom_range(0, 99);
                    dest = (r < 40) ? BCAST : (r < 80) ? cur_short : dest;
                    r = $urandom_range(0, 99);
                    guid = (r < 40) ? cur_eui : (r < 75) ? ALL_ONES_GUID : guid;
                    // few sources so that repeats and collisions both happen
                    r = $urandom_range(0, 99);
                    src = (r < 30) ? 16'($urandom_range(0, 3)) : (r < 45) ? BCAST : src;
                end
                else if (r < 45)
                    act = ACT_RX_RSP;
                else if (r < 57)
                begin
                    act = ACT_QRY_ADDR;
                    r = $urandom_range(0, 99);
                    src = (r < 15) ? 16'h0000 : (r < 25) ? BCAST : src;
                end
                else if (r < 69)
                begin
                    act = ACT_QRY_EUI;
                    r = $urandom_range(0, 99);
                    guid = (r < 15) ? 64'h0 : (r < 25) ? ALL_ONES_GUID : guid;
                end
                else if (r < 94)
                    act = ACT_SEND;
                else
                    act = 3'($urandom_range(5, 7));
                push_request(act, dest, src, guid);
                counted++;
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (open_results != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
